@@ design/admm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADMM sharing solver package
// Sizes, register codes, state types and saturating helpers.
// ----------------------------------------------------------------------------
package admm_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int ITERATIONS   = 20;

   localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int ITER_W = $clog2(ITERATIONS + 1);
   localparam int ACC_W  = 32 + CNT_W;
   localparam int DEN_W  = 33 + CNT_W;
   localparam int WIDE_W = 40;
   localparam int ADDR_W = 5;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [WIDE_W-1:0] WQ_MAX = {{(WIDE_W-32){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [WIDE_W-1:0] WQ_MIN = {{(WIDE_W-32){1'b1}}, 32'h8000_0000};
   localparam logic signed [DEN_W-1:0]  DEN_HALF = DEN_W'(32768);

   typedef enum logic [2:0] {
      REG_CURVATURE,
      REG_COST_CENTER,
      REG_PENALTY_WEIGHT,
      REG_UPPER_BOUND,
      REG_LOWER_BOUND,
      REG_ELEMENT_COUNT
   } reg_index_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_SUM,
      S_MSTART,
      S_MWAIT,
      S_SHMU,
      S_SHSTART,
      S_SHWAIT,
      S_ZMU,
      S_ZDEN,
      S_ZSTART,
      S_ZWAIT,
      S_DUAL,
      S_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      D_IDLE,
      D_ABS,
      D_CHK,
      D_RUN,
      D_FIN,
      D_DONE
   } div_state_type;

   typedef struct packed {
      logic                    start;
      logic signed [63:0]      num;
      logic signed [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic signed [31:0] quot;
   } div_rsp_type;

   function automatic logic signed [WIDE_W-1:0] sx_wide(input logic signed [31:0] v);
      return {{(WIDE_W-32){v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      if (v > WQ_MAX) begin
         r = Q_MAX;
      end else if (v < WQ_MIN) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // lower bound first, then upper: crossed bounds give the upper one
   function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
      logic signed [31:0] r;
      r = v;
      if (r < lo) begin
         r = lo;
      end
      if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/admm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADMM sharing solver channels
// Valid/ready interfaces for share pairs in and final shares out.
// ----------------------------------------------------------------------------
interface admm_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] start_share;
   logic signed [31:0] target_value;
   modport source (output valid, output start_share, output target_value, input ready);
   modport sink (input valid, input start_share, input target_value, output ready);
endinterface

interface admm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] share_value;
   logic               is_last;
   modport source (output valid, output share_value, output is_last, input ready);
   modport sink (input valid, input share_value, input is_last, output ready);
endinterface
`default_nettype wire

@@ design/admm_local_sharing_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADMM local sharing solver
// Loads N share pairs, runs the ADMM sharing iterations with one shared
// multiplier and one shared divider, then sends out the clamped shares.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// req_bus   in   valid/ready          start_share, target_value
// rsp_bus   out  valid/ready          share_value, is_last
// csr       in   APB (psel/penable)   6 registers at 4*i
//
// Loading takes one cycle per pair. The pair that fills N starts a solve of
// ITERATIONS iterations on the 32-step shared divider (one division per
// share plus two means and one for z per iteration), then the N shares are
// moved out in order. req_bus is not ready from solve start until the last
// share sits in the output register; a stalled rsp_bus holds the sequencer
// in the output phase. Synchronous reset clears control state; the share and
// target stores hold garbage until loaded.
// ----------------------------------------------------------------------------
module admm_local_sharing_solver import admm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   admm_req_if.sink                 req_bus,
   admm_rsp_if.source               rsp_bus,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [ADDR_W-1:0]   paddr,
   input  wire logic [31:0]         pwdata,
   output logic      [31:0]         prdata,
   output logic                     pready
);

   // ---------------- configuration registers ----------------
   logic signed [31:0] curv_ff, center_ff, upper_ff, lower_ff;
   logic [30:0]        alpha_ff;
   logic [4:0]         ecount_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         curv_ff   <= 32'sd65536;
         center_ff <= '0;
         alpha_ff  <= 31'd32768;
         upper_ff  <= 32'sd655360;
         lower_ff  <= '0;
         ecount_ff <= 5'd16;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CURVATURE:      curv_ff   <= pwdata;
            REG_COST_CENTER:    center_ff <= pwdata;
            REG_PENALTY_WEIGHT: alpha_ff  <= pwdata[30:0];
            REG_UPPER_BOUND:    upper_ff  <= pwdata;
            REG_LOWER_BOUND:    lower_ff  <= pwdata;
            REG_ELEMENT_COUNT:  ecount_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CURVATURE:      prdata = curv_ff;
         REG_COST_CENTER:    prdata = center_ff;
         REG_PENALTY_WEIGHT: prdata = {1'b0, alpha_ff};
         REG_UPPER_BOUND:    prdata = upper_ff;
         REG_LOWER_BOUND:    prdata = lower_ff;
         REG_ELEMENT_COUNT:  prdata = {27'b0, ecount_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------- state ----------------
   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic               pass_ff, pass_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0] mean_ff, mean_in;
   logic signed [31:0] mu_ff, mu_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [31:0] u_ff, u_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] num_ff, num_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_share_ff, rsp_share_in;
   logic               rsp_last_ff, rsp_last_in;

   logic signed [31:0] share_mem_ff  [MAX_ELEMENTS];
   logic signed [31:0] target_mem_ff [MAX_ELEMENTS];

   // store write port
   logic               share_we, target_we;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] share_wdata;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;

   div_req_type        dreq;
   div_rsp_type        drsp;

   logic [CNT_W-1:0]   n_act;
   logic [CNT_W-1:0]   slot;
   logic               idx_last;
   logic               req_xfer;
   logic               out_free;
   logic signed [31:0] share_rd, target_rd;
   logic signed [63:0] mu_scaled;

   admm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // element count: zero counts as one, above the store depth is capped
   always_comb begin
      if (ecount_ff == 5'd0) begin
         n_act = CNT_W'(1);
      end else if (int'(ecount_ff) > MAX_ELEMENTS) begin
         n_act = CNT_W'(MAX_ELEMENTS);
      end else begin
         n_act = CNT_W'(ecount_ff);
      end
   end

   assign slot      = (int'(load_cnt_ff) >= MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS - 1)
                                                          : load_cnt_ff;
   assign idx_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff);
   assign req_xfer  = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign share_rd  = share_mem_ff[idx_ff];
   assign target_rd = target_mem_ff[idx_ff];
   assign mu_scaled = {{17{mu_ff[31]}}, mu_ff, 15'b0};

   assign req_bus.ready     = (state_ff == S_LOAD);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.share_value = rsp_share_ff;
   assign rsp_bus.is_last   = rsp_last_ff;

   // multiplier operands by phase: alpha*y, a*x0, a*N
   always_comb begin
      case (state_ff)
         S_ZMU: begin
            mul_a = {curv_ff[31], curv_ff};
            mul_b = {center_ff[31], center_ff};
         end
         S_ZDEN: begin
            mul_a = {curv_ff[31], curv_ff};
            mul_b = {{(33-CNT_W){1'b0}}, n_ff};
         end
         default: begin
            mul_a = {2'b0, alpha_ff};
            mul_b = {target_rd[31], target_rd};
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:    if (req_xfer && ((slot + CNT_W'(1)) >= n_act)) state_in = S_SUM;
         S_SUM:     if (idx_last) state_in = S_MSTART;
         S_MSTART:  state_in = S_MWAIT;
         S_MWAIT:   if (drsp.done) state_in = pass_ff ? S_ZMU : S_SHMU;
         S_SHMU:    state_in = S_SHSTART;
         S_SHSTART: state_in = S_SHWAIT;
         S_SHWAIT:  if (drsp.done) state_in = idx_last ? S_SUM : S_SHMU;
         S_ZMU:     state_in = S_ZDEN;
         S_ZDEN:    state_in = S_ZSTART;
         S_ZSTART:  state_in = S_ZWAIT;
         S_ZWAIT:   if (drsp.done) state_in = S_DUAL;
         S_DUAL: begin
            state_in = ((iter_ff + ITER_W'(1)) == ITER_W'(ITERATIONS)) ? S_OUT : S_SUM;
         end
         S_OUT:     if (out_free && idx_last) state_in = S_LOAD;
         default:   state_in = S_LOAD;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      iter_in      = iter_ff;
      pass_in      = pass_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      mu_in        = mu_ff;
      z_in         = z_ff;
      u_in         = u_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_share_in = rsp_share_ff;
      rsp_last_in  = rsp_last_ff;
      share_we     = 1'b0;
      target_we    = 1'b0;
      wr_addr      = idx_ff;
      share_wdata  = drsp.quot;
      dreq.start   = 1'b0;
      dreq.num     = num_ff;
      dreq.den     = DEN_W'(prod_ff) + DEN_HALF;
      unique case (state_ff)
         S_LOAD: begin
            wr_addr     = slot[IDX_W-1:0];
            share_wdata = req_bus.start_share;
            if (req_xfer) begin
               share_we    = 1'b1;
               target_we   = 1'b1;
               load_cnt_in = slot + CNT_W'(1);
               if ((slot + CNT_W'(1)) >= n_act) begin
                  // solve starts: total and dual restart at zero
                  load_cnt_in = '0;
                  n_in        = n_act;
                  idx_in      = '0;
                  iter_in     = '0;
                  pass_in     = 1'b0;
                  acc_in      = '0;
                  z_in        = '0;
                  u_in        = '0;
               end
            end
         end
         S_SUM: begin
            acc_in = acc_ff + ACC_W'(share_rd);
            idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
         end
         S_MSTART: begin
            dreq.start = 1'b1;
            dreq.num   = 64'(acc_ff);
            dreq.den   = {{(DEN_W-CNT_W){1'b0}}, n_ff};
         end
         S_MWAIT: begin
            if (drsp.done) begin
               mean_in = drsp.quot;
            end
         end
         S_SHMU: begin
            mu_in   = sat32(sx_wide(share_rd) - sx_wide(mean_ff) + sx_wide(z_ff)
                            - sx_wide(u_ff));
            prod_in = mul_p[63:0];
         end
         S_SHSTART: begin
            dreq.start = 1'b1;
            dreq.num   = prod_ff + mu_scaled;
            dreq.den   = {{(DEN_W-31){1'b0}}, alpha_ff} + DEN_HALF;
         end
         S_SHWAIT: begin
            if (drsp.done) begin
               share_we = 1'b1;
               if (idx_last) begin
                  idx_in  = '0;
                  pass_in = 1'b1;
                  acc_in  = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_ZMU: begin
            mu_in   = sat32(sx_wide(u_ff) + sx_wide(mean_ff));
            prod_in = mul_p[63:0];
         end
         S_ZDEN: begin
            num_in  = prod_ff + mu_scaled;
            prod_in = mul_p[63:0];
         end
         S_ZSTART: begin
            dreq.start = 1'b1;
         end
         S_ZWAIT: begin
            if (drsp.done) begin
               z_in = clamp_q(drsp.quot, lower_ff, upper_ff);
            end
         end
         S_DUAL: begin
            u_in    = sat32(sx_wide(u_ff) + sx_wide(mean_ff) - sx_wide(z_ff));
            // count wraps to zero once the last iteration is done
            iter_in = ((iter_ff + ITER_W'(1)) == ITER_W'(ITERATIONS)) ? '0
                                                                      : iter_ff + ITER_W'(1);
            pass_in = 1'b0;
            acc_in  = '0;
            idx_in  = '0;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_share_in = clamp_q(share_rd, lower_ff, upper_ff);
               rsp_last_in  = idx_last;
               idx_in       = idx_last ? '0 : idx_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_cnt_ff  <= '0;
         n_ff         <= CNT_W'(1);
         idx_ff       <= '0;
         iter_ff      <= '0;
         pass_ff      <= 1'b0;
         z_ff         <= '0;
         u_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         iter_ff      <= iter_in;
         pass_ff      <= pass_in;
         z_ff         <= z_in;
         u_ff         <= u_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      mean_ff      <= mean_in;
      mu_ff        <= mu_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      rsp_share_ff <= rsp_share_in;
      rsp_last_ff  <= rsp_last_in;
      if (share_we) begin
         share_mem_ff[wr_addr] <= share_wdata;
      end
      if (target_we) begin
         target_mem_ff[wr_addr] <= req_bus.target_value;
      end
   end

   // ---------------- assertions ----------------
   a_div_idle_when_loading: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> !drsp.busy)
      else $error("divider busy while loading");

   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      int'(iter_ff) < ITERATIONS)
      else $error("iteration count out of range");

   a_load_range: assert property (@(posedge clock) disable iff (reset)
      int'(load_cnt_ff) < MAX_ELEMENTS)
      else $error("load count out of range");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> (CNT_W'(idx_ff) < n_ff))
      else $error("element index beyond count");

endmodule
`default_nettype wire

@@ design/admm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ADMM shared divider
// Signed restoring divider, one quotient bit per cycle, truncates toward
// zero and saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module admm_div import admm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   div_state_type state_ff, state_in;

   logic signed [63:0]      num_ff, num_in;
   logic signed [DEN_W-1:0] den_ff, den_in;
   logic [63:0]             mnum_ff, mnum_in;
   logic [DEN_W-1:0]        mden_ff, mden_in;
   logic                    neg_ff, neg_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [31:0]             low_ff, low_in;
   logic [31:0]             qbits_ff, qbits_in;
   logic [4:0]              step_ff, step_in;
   logic signed [31:0]      quot_ff, quot_in;

   logic                    overflow;
   logic [DEN_W:0]          trial;

   assign overflow = {{(DEN_W-32){1'b0}}, mnum_ff} >= {mden_ff, 32'b0};
   assign trial    = {rem_ff, low_ff[31]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         D_IDLE: if (req.start) state_in = D_ABS;
         D_ABS:  state_in = D_CHK;
         D_CHK:  state_in = ((den_ff == '0) || overflow) ? D_DONE : D_RUN;
         D_RUN:  if (step_ff == 5'd31) state_in = D_FIN;
         D_FIN:  state_in = D_DONE;
         D_DONE: state_in = D_IDLE;
         default: state_in = D_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rsp.busy = (state_ff != D_IDLE);
      rsp.done = (state_ff == D_DONE);
      rsp.quot = quot_ff;
   end

   // datapath
   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      mnum_in  = mnum_ff;
      mden_in  = mden_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      qbits_in = qbits_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      case (state_ff)
         D_IDLE: begin
            num_in = req.num;
            den_in = req.den;
         end
         D_ABS: begin
            neg_in  = num_ff[63] ^ den_ff[DEN_W-1];
            mnum_in = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
            mden_in = den_ff[DEN_W-1] ? DEN_W'(-den_ff) : DEN_W'(den_ff);
         end
         D_CHK: begin
            rem_in   = {{(DEN_W-32){1'b0}}, mnum_ff[63:32]};
            low_in   = mnum_ff[31:0];
            qbits_in = '0;
            step_in  = '0;
            if (den_ff == '0) begin
               // zero divisor: saturate toward the numerator's sign
               if (num_ff > 0) begin
                  quot_in = Q_MAX;
               end else if (num_ff < 0) begin
                  quot_in = Q_MIN;
               end else begin
                  quot_in = '0;
               end
            end else if (overflow) begin
               quot_in = neg_ff ? Q_MIN : Q_MAX;
            end
         end
         D_RUN: begin
            if (trial >= {1'b0, mden_ff}) begin
               rem_in   = DEN_W'(trial - {1'b0, mden_ff});
               qbits_in = {qbits_ff[30:0], 1'b1};
            end else begin
               rem_in   = trial[DEN_W-1:0];
               qbits_in = {qbits_ff[30:0], 1'b0};
            end
            low_in  = {low_ff[30:0], 1'b0};
            step_in = step_ff + 5'd1;
         end
         D_FIN: begin
            if (neg_ff) begin
               quot_in = (qbits_ff > 32'h8000_0000) ? Q_MIN : 32'(-qbits_ff);
            end else begin
               quot_in = (qbits_ff > 32'h7FFF_FFFF) ? Q_MAX : qbits_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      mnum_ff  <= mnum_in;
      mden_ff  <= mden_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      qbits_ff <= qbits_in;
      quot_ff  <= quot_in;
   end

endmodule
`default_nettype wire
